// ===== design/psh_pkg.sv =====
// Package for the payload segmenter: field widths, item types and command codes.
package psh_pkg;

    localparam int CHUNK_SIZE_W     = 13;
    localparam int HEADER_BYTES     = 8;
    localparam int HDR_IDX_W        = $clog2(HEADER_BYTES);
    localparam int S_TDATA_W        = 72;
    localparam int M_TDATA_W        = 8;
    localparam int M_TUSER_W        = 2;

    localparam logic [CHUNK_SIZE_W-1:0] CHUNK_SIZE_RESET = 13'd1024;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    localparam logic [HDR_IDX_W-1:0] HDR_IDX_LAST = HDR_IDX_W'(HEADER_BYTES - 1);

    typedef struct packed {
        logic        command;
        logic [31:0] frame_number;
        logic [31:0] total_size;
        logic [7:0]  data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_header;
        logic       end_of_packet;
        logic       last_of_run;
    } out_item_t;

endpackage

// ===== design/psh_in_stage.sv =====
// Input register stage: holds one accepted input transfer until the core takes it.
module psh_in_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [psh_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                           s_tuser,
    input  logic                           take,
    output logic                           item_valid,
    output psh_pkg::in_item_t              item
);
    import psh_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.command      <= s_tuser;
            item_reg.frame_number <= s_tdata[31:0];
            item_reg.total_size   <= s_tdata[63:32];
            item_reg.data_byte    <= s_tdata[71:64];
        end
    end

endmodule

// ===== design/psh_core.sv =====
// Segmenter core: payload state, header sequencer and chunk size register.
module psh_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [psh_pkg::CHUNK_SIZE_W-1:0]   cfg_data,
    input  logic                               in_valid,
    input  psh_pkg::in_item_t                  in_item,
    output logic                               in_take,
    input  logic                               out_free,
    output logic                               out_push,
    output psh_pkg::out_item_t                 out_item
);
    import psh_pkg::*;

    logic [CHUNK_SIZE_W-1:0] chunk_size_reg;
    logic [15:0]             frame_tag_reg,       frame_tag_next;
    logic [31:0]             declared_size_reg,   declared_size_next;
    logic [31:0]             bytes_remaining_reg, bytes_remaining_next;
    logic [CHUNK_SIZE_W-1:0] chunk_fill_reg,      chunk_fill_next;
    logic [15:0]             packet_number_reg,   packet_number_next;
    logic [HDR_IDX_W-1:0]    hdr_idx_reg,         hdr_idx_next;
    logic                    hdr_sent_reg,        hdr_sent_next;

    logic [CHUNK_SIZE_W-1:0] limit;
    logic [CHUNK_SIZE_W-1:0] fill_inc;
    logic                    eop;
    logic [7:0]              hdr_byte;

    assign cfg_ready = 1'b1;
    assign limit     = (chunk_size_reg == '0) ? CHUNK_SIZE_W'(1) : chunk_size_reg;
    assign fill_inc  = chunk_fill_reg + CHUNK_SIZE_W'(1);
    assign eop       = (fill_inc >= limit) || (bytes_remaining_reg == 32'd1);

    // Header is big-endian: frame tag, packet number, declared size.
    always_comb begin
        case (hdr_idx_reg)
            3'd0:    hdr_byte = frame_tag_reg[15:8];
            3'd1:    hdr_byte = frame_tag_reg[7:0];
            3'd2:    hdr_byte = packet_number_reg[15:8];
            3'd3:    hdr_byte = packet_number_reg[7:0];
            3'd4:    hdr_byte = declared_size_reg[31:24];
            3'd5:    hdr_byte = declared_size_reg[23:16];
            3'd6:    hdr_byte = declared_size_reg[15:8];
            default: hdr_byte = declared_size_reg[7:0];
        endcase
    end

    always_comb begin
        frame_tag_next       = frame_tag_reg;
        declared_size_next   = declared_size_reg;
        bytes_remaining_next = bytes_remaining_reg;
        chunk_fill_next      = chunk_fill_reg;
        packet_number_next   = packet_number_reg;
        hdr_idx_next         = hdr_idx_reg;
        hdr_sent_next        = hdr_sent_reg;
        in_take              = 1'b0;
        out_push             = 1'b0;
        out_item             = '0;

        if (in_valid) begin
            if (in_item.command == CMD_START) begin
                in_take              = 1'b1;
                frame_tag_next       = in_item.frame_number[15:0];
                declared_size_next   = in_item.total_size;
                bytes_remaining_next = in_item.total_size;
                chunk_fill_next      = '0;
                packet_number_next   = '0;
                hdr_idx_next         = '0;
                hdr_sent_next        = 1'b0;
            end else if (bytes_remaining_reg == '0) begin
                in_take = 1'b1;
            end else if (chunk_fill_reg == '0 && !hdr_sent_reg) begin
                if (out_free) begin
                    out_push           = 1'b1;
                    out_item.out_byte  = hdr_byte;
                    out_item.is_header = 1'b1;
                    hdr_idx_next       = hdr_idx_reg + HDR_IDX_W'(1);
                    if (hdr_idx_reg == HDR_IDX_LAST) begin
                        hdr_sent_next = 1'b1;
                    end
                end
            end else if (out_free) begin
                in_take                = 1'b1;
                out_push               = 1'b1;
                out_item.out_byte      = in_item.data_byte;
                out_item.end_of_packet = eop;
                out_item.last_of_run   = 1'b1;
                bytes_remaining_next   = bytes_remaining_reg - 32'd1;
                hdr_sent_next          = 1'b0;
                if (eop) begin
                    chunk_fill_next    = '0;
                    packet_number_next = packet_number_reg + 16'd1;
                end else begin
                    chunk_fill_next    = fill_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_size_reg      <= CHUNK_SIZE_RESET;
            frame_tag_reg       <= '0;
            declared_size_reg   <= '0;
            bytes_remaining_reg <= '0;
            chunk_fill_reg      <= '0;
            packet_number_reg   <= '0;
            hdr_idx_reg         <= '0;
            hdr_sent_reg        <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                chunk_size_reg <= cfg_data;
            end
            frame_tag_reg       <= frame_tag_next;
            declared_size_reg   <= declared_size_next;
            bytes_remaining_reg <= bytes_remaining_next;
            chunk_fill_reg      <= chunk_fill_next;
            packet_number_reg   <= packet_number_next;
            hdr_idx_reg         <= hdr_idx_next;
            hdr_sent_reg        <= hdr_sent_next;
        end
    end

endmodule

// ===== design/psh_out_stage.sv =====
// Output register stage: holds one result transfer until the sink takes it.
module psh_out_stage (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           push,
    input  psh_pkg::out_item_t             item,
    output logic                           free,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [psh_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [psh_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                           m_tlast
);
    import psh_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign free     = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata  = item_reg.out_byte;
    assign m_tuser  = {item_reg.last_of_run, item_reg.is_header};
    assign m_tlast  = item_reg.end_of_packet;

    always_comb begin
        valid_next = valid_reg;
        if (free) begin
            valid_next = push;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && free) begin
            item_reg <= item;
        end
    end

endmodule

// ===== design/payload_segmenter_with_header.sv =====
// Top level of the payload segmenter with per-packet sequence header.
//
//   channel  direction  handshake                 contents
//   s_       in         s_tvalid / s_tready       tdata: frame_number, total_size, data_byte
//                                                 tuser: command
//   m_       out        m_tvalid / m_tready       tdata: out_byte, tuser: is_header,
//                                                 last_of_run, tlast: end_of_packet
//   cfg_     in         cfg_valid / cfg_ready     cfg_data: chunk_payload_size
//
// One input transfer per cycle while the sink keeps up and no header is due; a data
// byte that opens a packet waits while the header sequencer sends eight header bytes.
// Start commands and dropped bytes are taken without producing output.
// Input and output each sit behind a register, so a stalled sink holds one result
// while the next input is still accepted. Synchronous active-low reset clears the
// valid flags and core state and sets the chunk size to 1024; cfg_ready is always high.
module payload_segmenter_with_header (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [psh_pkg::CHUNK_SIZE_W-1:0]   cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [psh_pkg::S_TDATA_W-1:0]      s_tdata,   // frame_number, total_size, data_byte
    input  logic                               s_tuser,   // command
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [psh_pkg::M_TDATA_W-1:0]      m_tdata,   // out_byte
    output logic [psh_pkg::M_TUSER_W-1:0]      m_tuser,   // is_header, last_of_run
    output logic                               m_tlast
);
    import psh_pkg::*;

    logic      in_valid;
    in_item_t  in_item;
    logic      in_take;
    logic      out_free;
    logic      out_push;
    out_item_t out_item;

    psh_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (in_take),
        .item_valid (in_valid),
        .item       (in_item)
    );

    psh_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .in_take   (in_take),
        .out_free  (out_free),
        .out_push  (out_push),
        .out_item  (out_item)
    );

    psh_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (out_push),
        .item     (out_item),
        .free     (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
